/* rtl/ssm_pkg.sv */
`timescale 1ns / 1ps

package ssm_pkg;

    localparam int OUT_DEPTH = 6;
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);
    localparam int IDX_W     = $clog2(OUT_DEPTH);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_LBRC   = 8'h7B;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_RBRC   = 8'h7D;

    typedef struct packed {
        logic [7:0] prev;
        logic [7:0] held;
        logic       held_v;
        logic       line_cmt;
        logic       block_cmt;
        logic       directive;
        logic       squeeze;
    } ssm_state_t;

    typedef struct packed {
        ssm_state_t st;
        logic [1:0] n;
        logic [7:0] e0;
        logic [7:0] e1;
    } ssm_judge_t;

    localparam ssm_state_t STATE_RESET = '{
        prev: CH_NUL, held: CH_NUL, held_v: 1'b0, line_cmt: 1'b0,
        block_cmt: 1'b0, directive: 1'b0, squeeze: 1'b1
    };

    function automatic logic is_newline(logic [7:0] c);
        logic r;
        case (c) inside
            CH_CR, CH_LF: r = 1'b1;
            default:      r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        logic r;
        case (c) inside
            CH_SPACE, CH_TAB, CH_CR, CH_LF: r = 1'b1;
            default:                        r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_operator(logic [7:0] c);
        logic r;
        case (c) inside
            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_EQ, CH_SEMI, CH_LPAR, CH_RPAR,
            CH_LBRC, CH_RBRC, CH_COMMA, CH_BAR, CH_AMP, CH_LT, CH_GT: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_squeeze(logic [7:0] c);
        return is_operator(c) || is_blank(c) || (c == CH_LBRK) || (c == CH_RBRK);
    endfunction

    // Judges one character once its following character is known.
    function automatic ssm_judge_t judge(ssm_state_t s, logic [7:0] c, logic [7:0] nx);
        ssm_judge_t r;
        logic [7:0] prior_char;
        logic       skip;
        r      = '{st: s, n: 2'd0, e0: CH_NUL, e1: CH_NUL};
        prior_char = s.prev;
        r.st.prev = c;
        if (c == CH_SLASH && nx == CH_SLASH)
        begin
            r.st.line_cmt = 1'b1;
        end
        if (c == CH_SLASH && nx == CH_STAR)
        begin
            r.st.block_cmt = 1'b1;
        end
        if (c == CH_HASH)
        begin
            r.st.directive = 1'b1;
        end
        if (is_newline(c))
        begin
            r.st.line_cmt = 1'b0;
        end
        skip = !r.st.directive && r.st.squeeze && is_blank(c);
        if (!skip)
        begin
            if (is_newline(c))
            begin
                r.st.directive = 1'b0;
            end
            r.st.squeeze = r.st.block_cmt || r.st.line_cmt || is_squeeze(c);
            if (r.st.squeeze && r.st.held_v && r.st.held == CH_SPACE && is_operator(c))
            begin
                r.st.held_v = 1'b0;
            end
            if (!r.st.line_cmt && !r.st.block_cmt)
            begin
                if (is_newline(c))
                begin
                    if (r.st.held_v)
                    begin
                        r.e0 = r.st.held;
                        r.e1 = CH_BSLASH;
                        r.n  = 2'd2;
                    end
                    else
                    begin
                        r.e0 = CH_BSLASH;
                        r.n  = 2'd1;
                    end
                    r.st.held = CH_N;
                end
                else
                begin
                    if (r.st.held_v)
                    begin
                        r.e0 = r.st.held;
                        r.n  = 2'd1;
                    end
                    r.st.held = c;
                end
                r.st.held_v = 1'b1;
            end
            if (r.st.block_cmt && c == CH_SLASH && prior_char == CH_STAR)
            begin
                r.st.block_cmt = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

/* rtl/shader_source_minifier_top.sv */
`timescale 1ns / 1ps

// Shader source minifier.
// The slave stream carries source text, one character per transfer in
// s_axis_tdata, with s_axis_tlast on the final character of a source.
// The master stream carries the minified text, one byte per transfer, and
// ends each source with a zero byte marked by m_axis_tlast.
// An accepted character is held in an input register; once the buffer is
// free, the comment, blank and line-break rules judge the pending character
// before it, with it as lookahead, and write up to six released bytes, the
// last source character's flush included, into a six-entry result buffer.
// The single byte-wide master port sets the pace: plain text runs at one
// character per cycle while the receiver is ready, and a character that
// releases two bytes, such as a kept line break, holds back the next one.
// A new character is taken while the last buffered byte is being sent.
// When the receiver stalls, the buffer holds its bytes and the input
// register fills, after which s_axis_tready falls until the buffer drains.
// Reset empties both registers and returns the minifier state to the start
// of a source; the end of each source also returns the state to the start.
module shader_source_minifier_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast
);

    logic                        in_valid_reg;
    logic [7:0]                  in_byte_reg;
    logic                        in_last_reg;
    logic [7:0]                  pend_reg;
    logic                        pend_v_reg;
    ssm_pkg::ssm_state_t         state_reg;
    logic [8:0]                  out_mem_reg [ssm_pkg::OUT_DEPTH];
    logic [ssm_pkg::CNT_W-1:0]   rem_reg;
    logic [ssm_pkg::IDX_W-1:0]   rd_reg;

    logic                        buf_free;
    logic                        advance;
    logic                        in_xfer;
    logic                        out_xfer;
    ssm_pkg::ssm_judge_t         j1;
    ssm_pkg::ssm_judge_t         j2;
    ssm_pkg::ssm_state_t         s1;
    ssm_pkg::ssm_state_t         state_next;
    logic [7:0]                  pend_next;
    logic                        pend_v_next;
    logic [8:0]                  ob [ssm_pkg::OUT_DEPTH];
    logic [ssm_pkg::CNT_W-1:0]   cnt;

    assign buf_free = (rem_reg == '0) ||
                      ((rem_reg == ssm_pkg::CNT_W'(1)) && m_axis_tready);
    assign advance  = in_valid_reg && buf_free;
    assign s_axis_tready = !in_valid_reg || buf_free;
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    assign m_axis_tvalid = (rem_reg != '0);
    assign m_axis_tdata  = out_mem_reg[rd_reg][7:0];
    assign m_axis_tlast  = out_mem_reg[rd_reg][8];

    always_comb
    begin
        j1  = ssm_pkg::judge(state_reg, pend_reg, in_byte_reg);
        s1  = pend_v_reg ? j1.st : state_reg;
        j2  = ssm_pkg::judge(s1, in_byte_reg, ssm_pkg::CH_NUL);
        cnt = '0;
        for (int i = 0; i < ssm_pkg::OUT_DEPTH; i++)
        begin
            ob[i] = '0;
        end
        if (pend_v_reg && j1.n != 2'd0)
        begin
            ob[cnt[ssm_pkg::IDX_W-1:0]] = {1'b0, j1.e0};
            cnt = cnt + 1'b1;
        end
        if (pend_v_reg && j1.n == 2'd2)
        begin
            ob[cnt[ssm_pkg::IDX_W-1:0]] = {1'b0, j1.e1};
            cnt = cnt + 1'b1;
        end
        if (in_last_reg)
        begin
            if (j2.n != 2'd0)
            begin
                ob[cnt[ssm_pkg::IDX_W-1:0]] = {1'b0, j2.e0};
                cnt = cnt + 1'b1;
            end
            if (j2.n == 2'd2)
            begin
                ob[cnt[ssm_pkg::IDX_W-1:0]] = {1'b0, j2.e1};
                cnt = cnt + 1'b1;
            end
            if (j2.st.held_v)
            begin
                ob[cnt[ssm_pkg::IDX_W-1:0]] = {1'b0, j2.st.held};
                cnt = cnt + 1'b1;
            end
            ob[cnt[ssm_pkg::IDX_W-1:0]] = {1'b1, ssm_pkg::CH_NUL};
            cnt = cnt + 1'b1;
            state_next  = ssm_pkg::STATE_RESET;
            pend_next   = ssm_pkg::CH_NUL;
            pend_v_next = 1'b0;
        end
        else
        begin
            state_next  = s1;
            pend_next   = in_byte_reg;
            pend_v_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            pend_reg     <= ssm_pkg::CH_NUL;
            pend_v_reg   <= 1'b0;
            state_reg    <= ssm_pkg::STATE_RESET;
            rem_reg      <= '0;
            rd_reg       <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                pend_reg   <= pend_next;
                pend_v_reg <= pend_v_next;
                state_reg  <= state_next;
                rem_reg    <= cnt;
                rd_reg     <= '0;
            end
            else if (out_xfer)
            begin
                rem_reg <= rem_reg - 1'b1;
                rd_reg  <= rd_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (advance)
        begin
            for (int i = 0; i < ssm_pkg::OUT_DEPTH; i++)
            begin
                out_mem_reg[i] <= ob[i];
            end
        end
    end

endmodule

/* rtl/ssm_checker.sv */
`timescale 1ns / 1ps

module ssm_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // A stalled result must hold its value until the transfer completes.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // The end of a stream is always the zero byte.
    a_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == 8'h00)
        else $error("stream end carries a nonzero byte");

    // With nothing waiting on the output, the input side is never blocked.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output");

    // A waiting source character stays unchanged until it is taken.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=>
        s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast))
        else $error("input changed while stalled");

endmodule

bind shader_source_minifier_top ssm_checker u_ssm_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
